[rtl/assert_macros.svh]
// assertion macros for the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion, sampled on clk, off while rst_n is low
`define LBP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbp assertion failed");
// the expression must never hold outside reset
`define LBP_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("lbp forbidden condition");
`endif

[rtl/lbp_pkg.sv]
// types, codes, constants and cost arithmetic of the lattice beam pruner
// no dependencies
package lbp_pkg;

  localparam int unsigned DEF_MAX_STATES = 1024;
  localparam int unsigned DEF_MAX_ARCS   = 4096;
  localparam logic [30:0] BEAM_RESET     = 31'd10240;

  localparam logic signed [31:0] COST_INF = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COST_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CMD_WR_ARC   = 3'd0,
    CMD_WR_FINAL = 3'd1,
    CMD_RUN      = 3'd2,
    CMD_RD_ARC   = 3'd3,
    CMD_RD_STATE = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_ARC, ST_RD_STATE, ST_INIT,
    ST_F_ARC, ST_F_CHK, ST_F_RELAX, ST_F_FIN_RD, ST_F_FIN,
    ST_CUT, ST_COPY_RD, ST_COPY_WR,
    ST_B_ST, ST_B_FIN, ST_B_ARC, ST_B_CHK, ST_B_UPD, ST_DONE
  } state_e;

  typedef struct packed {
    logic [9:0]         src;
    logic [9:0]         dst;
    logic signed [31:0] w;
  } arc_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic               kept;
  } fin_t;

  // saturating add, infinity absorbs
  function automatic logic signed [31:0] cost_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (a == COST_INF || b == COST_INF) begin
      r = COST_INF;
    end else if (!s[32] && (s[31] || (&s[30:0]))) begin
      r = COST_INF;
    end else if (s[32] && !s[31]) begin
      r = COST_MIN;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/lbp_arc_store.sv]
// arc memory (source, destination, cost) and pruned flag memory
// depends on lbp_pkg
module lbp_arc_store #(
  parameter int unsigned MAX_ARCS = lbp_pkg::DEF_MAX_ARCS,
  parameter int unsigned AW = $clog2(MAX_ARCS)
) (
  input  logic            clk_i,
  input  logic [AW-1:0]   rd_addr_i,
  input  logic            arc_we_i,
  input  logic [AW-1:0]   arc_waddr_i,
  input  lbp_pkg::arc_t   arc_wdata_i,
  input  logic            prn_we_i,
  input  logic [AW-1:0]   prn_waddr_i,
  input  logic            prn_wdata_i,
  output lbp_pkg::arc_t   arc_rdata_o,
  output logic            prn_rdata_o
);
  import lbp_pkg::*;

  arc_t arc_mem [MAX_ARCS];
  logic prn_mem [MAX_ARCS];

  always_ff @(posedge clk_i) begin
    if (arc_we_i) begin
      arc_mem[arc_waddr_i] <= arc_wdata_i;
    end
    if (prn_we_i) begin
      prn_mem[prn_waddr_i] <= prn_wdata_i;
    end
    arc_rdata_o <= arc_mem[rd_addr_i];
    prn_rdata_o <= prn_mem[rd_addr_i];
  end

endmodule

[rtl/lbp_state_store.sv]
// per-state memories: final cost with kept flag, forward and backward costs
// depends on lbp_pkg
module lbp_state_store #(
  parameter int unsigned MAX_STATES = lbp_pkg::DEF_MAX_STATES,
  parameter int unsigned SW = $clog2(MAX_STATES)
) (
  input  logic                 clk_i,
  input  logic [SW-1:0]        fin_raddr_i,
  input  logic                 fin_we_i,
  input  logic [SW-1:0]        fin_waddr_i,
  input  lbp_pkg::fin_t        fin_wdata_i,
  output lbp_pkg::fin_t        fin_rdata_o,
  input  logic [SW-1:0]        fwd_raddr_a_i,
  input  logic [SW-1:0]        fwd_raddr_b_i,
  input  logic                 fwd_we_i,
  input  logic [SW-1:0]        fwd_waddr_i,
  input  logic signed [31:0]   fwd_wdata_i,
  output logic signed [31:0]   fwd_rdata_a_o,
  output logic signed [31:0]   fwd_rdata_b_o,
  input  logic [SW-1:0]        bwd_raddr_a_i,
  input  logic [SW-1:0]        bwd_raddr_b_i,
  input  logic                 bwd_we_i,
  input  logic [SW-1:0]        bwd_waddr_i,
  input  logic signed [31:0]   bwd_wdata_i,
  output logic signed [31:0]   bwd_rdata_a_o,
  output logic signed [31:0]   bwd_rdata_b_o
);
  import lbp_pkg::*;

  fin_t               fin_mem [MAX_STATES];
  logic signed [31:0] fwd_mem [MAX_STATES];
  logic signed [31:0] bwd_mem [MAX_STATES];

  always_ff @(posedge clk_i) begin
    if (fin_we_i) begin
      fin_mem[fin_waddr_i] <= fin_wdata_i;
    end
    if (fwd_we_i) begin
      fwd_mem[fwd_waddr_i] <= fwd_wdata_i;
    end
    if (bwd_we_i) begin
      bwd_mem[bwd_waddr_i] <= bwd_wdata_i;
    end
    fin_rdata_o   <= fin_mem[fin_raddr_i];
    fwd_rdata_a_o <= fwd_mem[fwd_raddr_a_i];
    fwd_rdata_b_o <= fwd_mem[fwd_raddr_b_i];
    bwd_rdata_a_o <= bwd_mem[bwd_raddr_a_i];
    bwd_rdata_b_o <= bwd_mem[bwd_raddr_b_i];
  end

endmodule

[rtl/lattice_beam_pruner.sv]
// lattice beam pruner top level: command decode, run sequencer, output register
// depends on lbp_pkg, lbp_arc_store, lbp_state_store
//
// usage
//   s_axis carries commands: write arc, write final cost, run, read arc,
//   read state. m_axis carries one result for run, read arc and read state.
//   beam_width_i is written whenever beam_width_we_i is high; the user
//   must raise beam_width_we_i only while idle; the block does not enforce this.
// sequencing
//   writes give no result and may follow each other back to back. reads pass
//   through the memory read register and the output register. a run walks every
//   arc once per state in both passes through one arc memory read port and then
//   loads its result into the output register. the next command is taken only
//   after the previous result has left.
// reset
//   rst_ni clears control and beam_width to 10240; memory contents are kept
//   and are undefined until written.
// stall
//   a result waits in the output register while m_axis_tready is low; no new
//   transaction is taken meanwhile.
module lattice_beam_pruner #(
  parameter int unsigned MAX_STATES = lbp_pkg::DEF_MAX_STATES,
  parameter int unsigned MAX_ARCS   = lbp_pkg::DEF_MAX_ARCS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0], arc_index[14:3], state_index[24:15], dest_state[34:25], cost[66:35]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // flag[0], value[32:1]
  output logic [39:0] m_axis_tdata,
  input  logic        beam_width_we_i,
  input  logic [30:0] beam_width_i
);
  import lbp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ARCS);
  localparam int unsigned SW = $clog2(MAX_STATES);

  // input fields
  logic [2:0]         in_cmd;
  logic [11:0]        in_ai;
  logic [9:0]         in_si;
  logic [9:0]         in_ds;
  logic signed [31:0] in_cost;
  logic               in_acc;

  assign in_cmd  = s_axis_tdata[2:0];
  assign in_ai   = s_axis_tdata[14:3];
  assign in_si   = s_axis_tdata[24:15];
  assign in_ds   = s_axis_tdata[34:25];
  assign in_cost = s_axis_tdata[66:35];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  state_e             state_q, state_d;
  logic [30:0]        beam_q;
  logic [AW:0]        a_q, a_d;        // arc counter, reaches the arc count
  logic [AW:0]        na_q, na_d;      // arcs in the run
  logic [SW-1:0]      s_q, s_d;        // current state
  logic [SW-1:0]      last_q, last_d;  // last state in the run
  logic [9:0]         start_q, start_d;
  logic signed [31:0] best_q, best_d;
  logic signed [31:0] cut_q, cut_d;
  logic signed [31:0] fs_q, fs_d;      // forward cost of current state
  logic               ok_q, ok_d;      // read index in range
  logic               ov_q, ov_d;
  logic               of_q, of_d;
  logic signed [31:0] oval_q, oval_d;

  // memory ports
  logic [AW-1:0]      arc_ra, arc_wa, prn_wa;
  logic               arc_we, prn_we, prn_wd;
  arc_t               arc_wd, arc_rd;
  logic               prn_rd;
  logic [SW-1:0]      fin_ra, fin_wa, fwd_ra, fwd_rb, fwd_wa, bwd_ra, bwd_rb, bwd_wa;
  logic               fin_we, fwd_we, bwd_we;
  fin_t               fin_wd, fin_rd;
  logic signed [31:0] fwd_wd, fwd_a, fwd_b, bwd_wd, bwd_a, bwd_b;

  lbp_arc_store #(.MAX_ARCS(MAX_ARCS), .AW(AW)) u_arcs (
    .clk_i       (clk_i),
    .rd_addr_i   (arc_ra),
    .arc_we_i    (arc_we),
    .arc_waddr_i (arc_wa),
    .arc_wdata_i (arc_wd),
    .prn_we_i    (prn_we),
    .prn_waddr_i (prn_wa),
    .prn_wdata_i (prn_wd),
    .arc_rdata_o (arc_rd),
    .prn_rdata_o (prn_rd)
  );

  lbp_state_store #(.MAX_STATES(MAX_STATES), .SW(SW)) u_states (
    .clk_i         (clk_i),
    .fin_raddr_i   (fin_ra),
    .fin_we_i      (fin_we),
    .fin_waddr_i   (fin_wa),
    .fin_wdata_i   (fin_wd),
    .fin_rdata_o   (fin_rd),
    .fwd_raddr_a_i (fwd_ra),
    .fwd_raddr_b_i (fwd_rb),
    .fwd_we_i      (fwd_we),
    .fwd_waddr_i   (fwd_wa),
    .fwd_wdata_i   (fwd_wd),
    .fwd_rdata_a_o (fwd_a),
    .fwd_rdata_b_o (fwd_b),
    .bwd_raddr_a_i (bwd_ra),
    .bwd_raddr_b_i (bwd_rb),
    .bwd_we_i      (bwd_we),
    .bwd_waddr_i   (bwd_wa),
    .bwd_wdata_i   (bwd_wd),
    .bwd_rdata_a_o (bwd_a),
    .bwd_rdata_b_o (bwd_b)
  );

  // arc read last cycle belongs to this state and to the run and is not pruned
  logic               arc_hit;
  logic signed [31:0] relax_c, fin_sum, ab, fab;

  assign arc_hit = (32'(arc_rd.src) == 32'(s_q)) && (32'(arc_rd.dst) <= 32'(last_q))
                   && !prn_rd;
  assign relax_c = cost_add(fwd_a, arc_rd.w);
  assign fin_sum = cost_add(fwd_a, fin_rd.w);
  assign ab      = cost_add(arc_rd.w, bwd_b);
  assign fab     = cost_add(fs_q, ab);

  assign s_axis_tready = (state_q == ST_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, oval_q, of_q};

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    na_d    = na_q;
    s_d     = s_q;
    last_d  = last_q;
    start_d = start_q;
    best_d  = best_q;
    cut_d   = cut_q;
    fs_d    = fs_q;
    ok_d    = ok_q;
    ov_d    = ov_q && !m_axis_tready;
    of_d    = of_q;
    oval_d  = oval_q;
    arc_ra  = a_q[AW-1:0];
    arc_we  = 1'b0;
    arc_wa  = AW'(in_ai);
    arc_wd  = '{src: in_si, dst: in_ds, w: in_cost};
    prn_we  = 1'b0;
    prn_wa  = AW'(in_ai);
    prn_wd  = 1'b0;
    fin_ra  = s_q;
    fin_we  = 1'b0;
    fin_wa  = SW'(in_si);
    fin_wd  = '{w: in_cost, kept: 1'b1};
    fwd_ra  = s_q;
    fwd_rb  = SW'(arc_rd.dst);
    fwd_we  = 1'b0;
    fwd_wa  = SW'(arc_rd.dst);
    fwd_wd  = relax_c;
    bwd_ra  = s_q;
    bwd_rb  = SW'(arc_rd.dst);
    bwd_we  = 1'b0;
    bwd_wa  = s_q;
    bwd_wd  = ab;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_WR_ARC: begin
              arc_we = 32'(in_ai) < MAX_ARCS;
              prn_we = 32'(in_ai) < MAX_ARCS;
            end
            CMD_WR_FINAL: begin
              fin_we = 32'(in_si) < MAX_STATES;
            end
            CMD_RUN: begin
              na_d    = (32'(in_ai) + 32'd1 > MAX_ARCS) ? (AW+1)'(MAX_ARCS)
                                                       : (AW+1)'(32'(in_ai) + 32'd1);
              last_d  = (32'(in_ds) >= MAX_STATES) ? SW'(MAX_STATES - 1) : SW'(in_ds);
              start_d = in_si;
              s_d     = '0;
              state_d = ST_INIT;
            end
            CMD_RD_ARC: begin
              arc_ra  = AW'(in_ai);
              ok_d    = 32'(in_ai) < MAX_ARCS;
              state_d = ST_RD_ARC;
            end
            CMD_RD_STATE: begin
              fin_ra  = SW'(in_si);
              fwd_ra  = SW'(in_si);
              ok_d    = 32'(in_si) < MAX_STATES;
              state_d = ST_RD_STATE;
            end
            default: ;
          endcase
        end
      end
      ST_RD_ARC: begin
        ov_d    = 1'b1;
        of_d    = ok_q && prn_rd;
        oval_d  = '0;
        state_d = ST_IDLE;
      end
      ST_RD_STATE: begin
        ov_d    = 1'b1;
        of_d    = ok_q && fin_rd.kept;
        oval_d  = ok_q ? fwd_a : '0;
        state_d = ST_IDLE;
      end
      // forward costs start at infinity, zero at the start state
      ST_INIT: begin
        fwd_we = 1'b1;
        fwd_wa = s_q;
        fwd_wd = (32'(start_q) == 32'(s_q)) ? '0 : COST_INF;
        if (s_q == last_q) begin
          s_d     = '0;
          a_d     = '0;
          best_d  = COST_INF;
          state_d = ST_F_ARC;
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      ST_F_ARC: begin
        state_d = (a_q == na_q) ? ST_F_FIN_RD : ST_F_CHK;
      end
      ST_F_CHK: begin
        if (arc_hit) begin
          state_d = ST_F_RELAX;
        end else begin
          a_d     = a_q + 1'b1;
          state_d = ST_F_ARC;
        end
      end
      ST_F_RELAX: begin
        fwd_we  = fwd_b > relax_c;
        a_d     = a_q + 1'b1;
        state_d = ST_F_ARC;
      end
      ST_F_FIN_RD: begin
        state_d = ST_F_FIN;
      end
      ST_F_FIN: begin
        if (fin_sum < best_q) begin
          best_d = fin_sum;
        end
        a_d = '0;
        if (s_q == last_q) begin
          state_d = ST_CUT;
        end else begin
          s_d     = s_q + 1'b1;
          state_d = ST_F_ARC;
        end
      end
      ST_CUT: begin
        cut_d   = (best_q == COST_INF) ? COST_INF : cost_add(best_q, {1'b0, beam_q});
        s_d     = '0;
        state_d = ST_COPY_RD;
      end
      // backward costs start as a copy of the forward costs
      ST_COPY_RD: begin
        state_d = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        bwd_we = 1'b1;
        bwd_wd = fwd_a;
        if (s_q == last_q) begin
          state_d = ST_B_ST;
        end else begin
          s_d     = s_q + 1'b1;
          state_d = ST_COPY_RD;
        end
      end
      ST_B_ST: begin
        state_d = ST_B_FIN;
      end
      ST_B_FIN: begin
        bwd_we = 1'b1;
        bwd_wd = fin_rd.w;
        fs_d   = fwd_a;
        if (fin_sum > cut_q && fin_rd.w != COST_INF) begin
          fin_we = 1'b1;
          fin_wa = s_q;
          fin_wd = '{w: COST_INF, kept: 1'b0};
        end
        a_d     = '0;
        state_d = ST_B_ARC;
      end
      ST_B_ARC: begin
        if (a_q == na_q) begin
          if (s_q == '0) begin
            state_d = ST_DONE;
          end else begin
            s_d     = s_q - 1'b1;
            state_d = ST_B_ST;
          end
        end else begin
          state_d = ST_B_CHK;
        end
      end
      ST_B_CHK: begin
        if (arc_hit) begin
          state_d = ST_B_UPD;
        end else begin
          a_d     = a_q + 1'b1;
          state_d = ST_B_ARC;
        end
      end
      ST_B_UPD: begin
        bwd_we  = bwd_a > ab;
        prn_we  = fab > cut_q;
        prn_wa  = a_q[AW-1:0];
        prn_wd  = 1'b1;
        a_d     = a_q + 1'b1;
        state_d = ST_B_ARC;
      end
      ST_DONE: begin
        ov_d    = 1'b1;
        of_d    = 1'b0;
        oval_d  = best_q;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      beam_q  <= BEAM_RESET;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (beam_width_we_i) begin
        beam_q <= beam_width_i;
      end
    end
  end

  // payload and sequencing registers, qualified by state
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    na_q    <= na_d;
    s_q     <= s_d;
    last_q  <= last_d;
    start_q <= start_d;
    best_q  <= best_d;
    cut_q   <= cut_d;
    fs_q    <= fs_d;
    ok_q    <= ok_d;
    of_q    <= of_d;
    oval_q  <= oval_d;
  end

endmodule

[rtl/lbp_checker.sv]
// port-level checker for the lattice beam pruner, bound to the top level
// depends on assert_macros.svh, lbp_pkg and lattice_beam_pruner
`include "assert_macros.svh"
module lbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import lbp_pkg::*;

  `LBP_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `LBP_NEVER(a_no_take_pending, clk_i, rst_ni, m_axis_tvalid && s_axis_tready)
  `LBP_ASSERT(a_write_quiet, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] == CMD_WR_ARC |=> !m_axis_tvalid)
  `LBP_ASSERT(a_read_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] == CMD_RD_ARC |=> !s_axis_tready)

endmodule

bind lattice_beam_pruner lbp_checker u_lbp_checker (.*);
